// ----- rtl/gpib_byte_handshake_engine_top_defines.svh -----
// Assertion macros for the GPIB byte handshake engine.
// Used by the top level only; relies on signals named clk and rst in scope.
`ifndef GPIB_BYTE_HANDSHAKE_ENGINE_TOP_DEFINES_SVH
`define GPIB_BYTE_HANDSHAKE_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GBHE_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gbhe: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GBHE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gbhe: next-cycle check failed");

`endif

// ----- rtl/gbhe_pkg.sv -----
// Shared types, codes and reset values for the GPIB byte handshake engine.
// No dependencies; used by gbhe_step and the top level.
package gbhe_pkg;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_TALK_HOLD   = 4'd1,
    PH_LISTEN_HOLD = 4'd2,
    PH_S_NDAC_LOW  = 4'd3,
    PH_S_NRFD_HIGH = 4'd4,
    PH_S_NDAC_HIGH = 4'd5,
    PH_R_DAV_LOW   = 4'd6,
    PH_R_DAV_HIGH  = 4'd7
  } phase_t;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_RECV   = 2'd2;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [1:0] CLS_MORE    = 2'd0;
  localparam logic [1:0] CLS_FINAL   = 2'd1;
  localparam logic [1:0] CLS_DROPPED = 2'd2;

  localparam logic [1:0] REG_TIMEOUT_SECONDS = 2'd0;
  localparam logic [1:0] REG_USE_END_LINE    = 2'd1;
  localparam logic [1:0] REG_END_BYTE        = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET  = 8'd5;
  localparam logic       END_LINE_RESET = 1'b1;
  localparam logic [7:0] END_BYTE_RESET = 8'd10;
  localparam logic [7:0] TICK_MAX       = 8'hff;
  localparam logic [7:0] BYTE_INVERT    = 8'hff;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] send_byte;
    logic       is_command;
    logic       is_last;
    logic       ndac_high;
    logic       nrfd_high;
    logic       dav_high;
    logic       eoi_high;
    logic [7:0] bus_data;
    logic       second_tick;
  } in_item_t;

  typedef struct packed {
    logic       busy_res;
    logic [7:0] data_drive;
    logic       talk_enable;
    logic       atn_low;
    logic       eoi_low;
    logic       dav_low;
    logic       nrfd_low;
    logic       ndac_low;
    logic [1:0] result_status;
    logic [7:0] received_byte;
    logic [1:0] receive_class;
  } out_item_t;

  typedef struct packed {
    logic [7:0] timeout_seconds;
    logic       use_end_line;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] tick_count;
    logic [7:0] held_byte;
    logic       held_command;
    logic       held_last;
  } eng_state_t;

  function automatic logic is_wait(input phase_t p);
    logic w;
    case (p)
      PH_S_NDAC_LOW, PH_S_NRFD_HIGH, PH_S_NDAC_HIGH,
      PH_R_DAV_LOW, PH_R_DAV_HIGH: w = 1'b1;
      default:                     w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/gbhe_step.sv -----
// Handshake state and the per-item next-state and line-drive logic.
// Depends on gbhe_pkg; the caller registers items in and results out.
module gbhe_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  gbhe_pkg::in_item_t  item,
  input  gbhe_pkg::cfg_t      cfg,
  output gbhe_pkg::out_item_t res,
  output gbhe_pkg::eng_state_t st
);

  gbhe_pkg::eng_state_t nxt;
  gbhe_pkg::eng_state_t st_next;
  logic [7:0] cnt;
  logic       seen;
  logic       timed_out;
  logic       eq;
  logic       final_byte;
  logic [1:0] status;
  logic [7:0] rx;
  logic [1:0] cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= gbhe_pkg::PH_IDLE;
      st.tick_count   <= '0;
      st.held_byte    <= '0;
      st.held_command <= 1'b0;
      st.held_last    <= 1'b0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // The tick of this cycle is counted before the level check; the count saturates.
  assign cnt = (item.second_tick && (st.tick_count != gbhe_pkg::TICK_MAX))
             ? st.tick_count + 8'd1 : st.tick_count;
  assign timed_out = (cnt >= cfg.timeout_seconds);
  assign eq = (st.held_byte == cfg.end_byte);

  always_comb begin
    nxt        = st;
    status     = gbhe_pkg::ST_NONE;
    rx         = '0;
    cls        = gbhe_pkg::CLS_MORE;
    seen       = 1'b0;
    final_byte = 1'b0;
    if (!gbhe_pkg::is_wait(st.phase)) begin
      if (item.operation == gbhe_pkg::OP_SEND) begin
        nxt.held_byte    = item.send_byte;
        nxt.held_command = item.is_command;
        nxt.held_last    = item.is_last;
        nxt.tick_count   = '0;
        nxt.phase        = gbhe_pkg::PH_S_NDAC_LOW;
      end else if (item.operation == gbhe_pkg::OP_RECV) begin
        nxt.held_last  = 1'b0;
        nxt.tick_count = '0;
        nxt.phase      = gbhe_pkg::PH_R_DAV_LOW;
      end
    end else begin
      case (st.phase)
        gbhe_pkg::PH_S_NDAC_LOW: begin
          seen = !item.ndac_high;
          if (seen) nxt.phase = gbhe_pkg::PH_S_NRFD_HIGH;
        end
        gbhe_pkg::PH_S_NRFD_HIGH: begin
          seen = item.nrfd_high;
          if (seen) nxt.phase = gbhe_pkg::PH_S_NDAC_HIGH;
        end
        gbhe_pkg::PH_S_NDAC_HIGH: begin
          seen = item.ndac_high;
          if (seen) begin
            status    = gbhe_pkg::ST_DONE;
            nxt.phase = st.held_last ? gbhe_pkg::PH_IDLE : gbhe_pkg::PH_TALK_HOLD;
          end
        end
        gbhe_pkg::PH_R_DAV_LOW: begin
          seen = !item.dav_high;
          if (seen) begin
            nxt.held_byte = item.bus_data ^ gbhe_pkg::BYTE_INVERT;
            nxt.held_last = !item.eoi_high;
            nxt.phase     = gbhe_pkg::PH_R_DAV_HIGH;
          end
        end
        default: begin
          seen = item.dav_high;
          if (seen) begin
            if (cfg.use_end_line) begin
              final_byte = st.held_last;
              cls = !final_byte ? gbhe_pkg::CLS_MORE
                  : (eq ? gbhe_pkg::CLS_DROPPED : gbhe_pkg::CLS_FINAL);
            end else begin
              final_byte = eq;
              cls = eq ? gbhe_pkg::CLS_DROPPED : gbhe_pkg::CLS_MORE;
            end
            status    = gbhe_pkg::ST_DONE;
            rx        = st.held_byte;
            nxt.phase = final_byte ? gbhe_pkg::PH_IDLE : gbhe_pkg::PH_LISTEN_HOLD;
          end
        end
      endcase
      if (seen) begin
        nxt.tick_count = '0;
      end else if (timed_out) begin
        // A timeout releases every line by falling back to idle.
        nxt.tick_count = '0;
        status         = gbhe_pkg::ST_TIMEOUT;
        nxt.phase      = gbhe_pkg::PH_IDLE;
      end else begin
        nxt.tick_count = cnt;
      end
    end
    st_next = nxt;
  end

  // Line drives follow the phase after this item.
  always_comb begin
    res               = '0;
    res.busy_res      = gbhe_pkg::is_wait(nxt.phase);
    case (nxt.phase)
      gbhe_pkg::PH_TALK_HOLD, gbhe_pkg::PH_S_NDAC_LOW,
      gbhe_pkg::PH_S_NRFD_HIGH, gbhe_pkg::PH_S_NDAC_HIGH: begin
        res.data_drive  = nxt.held_byte ^ gbhe_pkg::BYTE_INVERT;
        res.talk_enable = 1'b1;
        res.atn_low     = nxt.held_command;
        if (nxt.phase == gbhe_pkg::PH_S_NDAC_HIGH) begin
          res.eoi_low = nxt.held_last && !nxt.held_command;
          res.dav_low = 1'b1;
        end
      end
      gbhe_pkg::PH_R_DAV_LOW: res.ndac_low = 1'b1;
      gbhe_pkg::PH_R_DAV_HIGH: res.nrfd_low = 1'b1;
      gbhe_pkg::PH_LISTEN_HOLD: begin
        res.nrfd_low = 1'b1;
        res.ndac_low = 1'b1;
      end
      default: ;
    endcase
    res.result_status = status;
    res.received_byte = rx;
    res.receive_class = cls;
  end

endmodule

// ----- rtl/gpib_byte_handshake_engine_top.sv -----
// GPIB byte handshake engine: one bus sample item in, one result item out.
// Each item waits in the input register and its result in the result register.
// Throughput: one item per cycle unless the result register stalls; the state
// update through gbhe_step is a single short pass between the input and result registers.
// Reset (synchronous, rst high): idle with lines released, tick count and held
// byte zero, registers timeout 5, use_end_line 1, end_byte 10.
`include "gpib_byte_handshake_engine_top_defines.svh"

module gpib_byte_handshake_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] send_byte, [8] ndac_high, [9] nrfd_high, [10] dav_high,
  // [11] eoi_high, [19:12] bus_data, [20] second_tick, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  // [1:0] operation, [2] is_command
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] busy_res, [8:1] data_drive, [9] talk_enable, [10] atn_low,
  // [11] eoi_low, [12] dav_low, [13] nrfd_low, [14] ndac_low,
  // [22:15] received_byte, [23] zero
  output logic [23:0] m_axis_tdata,
  // [1:0] result_status, [3:2] receive_class
  output logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  gbhe_pkg::cfg_t       cfg;
  gbhe_pkg::in_item_t   in_item;
  gbhe_pkg::in_item_t   in_reg;
  gbhe_pkg::out_item_t  res;
  gbhe_pkg::out_item_t  out_reg;
  gbhe_pkg::eng_state_t st;
  logic                 in_valid;
  logic                 advance;
  logic                 out_timeout;
  logic                 out_classed;
  logic                 lines_released;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_seconds <= gbhe_pkg::TIMEOUT_RESET;
      cfg.use_end_line    <= gbhe_pkg::END_LINE_RESET;
      cfg.end_byte        <= gbhe_pkg::END_BYTE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbhe_pkg::REG_TIMEOUT_SECONDS: cfg.timeout_seconds <= cfg_data;
        gbhe_pkg::REG_USE_END_LINE:    cfg.use_end_line    <= cfg_data[0];
        gbhe_pkg::REG_END_BYTE:        cfg.end_byte        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.operation   = s_axis_tuser[1:0];
    in_item.is_command  = s_axis_tuser[2];
    in_item.is_last     = s_axis_tlast;
    in_item.send_byte   = s_axis_tdata[7:0];
    in_item.ndac_high   = s_axis_tdata[8];
    in_item.nrfd_high   = s_axis_tdata[9];
    in_item.dav_high    = s_axis_tdata[10];
    in_item.eoi_high    = s_axis_tdata[11];
    in_item.bus_data    = s_axis_tdata[19:12];
    in_item.second_tick = s_axis_tdata[20];
  end

  // The input register moves on whenever the result register is free or drains.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg <= in_item;
    end
  end

  gbhe_step u_step (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_reg),
    .cfg  (cfg),
    .res  (res),
    .st   (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_reg.received_byte, out_reg.ndac_low, out_reg.nrfd_low,
                         out_reg.dav_low, out_reg.eoi_low, out_reg.atn_low,
                         out_reg.talk_enable, out_reg.data_drive, out_reg.busy_res};
  assign m_axis_tuser = {out_reg.receive_class, out_reg.result_status};

  assign out_timeout    = m_axis_tvalid && (out_reg.result_status == gbhe_pkg::ST_TIMEOUT);
  assign out_classed    = m_axis_tvalid && (out_reg.receive_class != gbhe_pkg::CLS_MORE);
  assign lines_released = (m_axis_tdata[14:0] == 15'd0);

  // The tick counter only runs inside a handshake wait.
  `GBHE_ASSERT_NOW(a_tick_idle_zero, !gbhe_pkg::is_wait(st.phase), st.tick_count == 8'd0)
  // A timeout result always comes with every line released.
  `GBHE_ASSERT_NOW(a_timeout_released, out_timeout, lines_released)
  // A receive class other than "more follow" only accompanies a finished byte.
  `GBHE_ASSERT_NOW(a_class_needs_done, out_classed, out_reg.result_status == gbhe_pkg::ST_DONE)
  // Every item that leaves the input register shows up as a result next cycle.
  `GBHE_ASSERT_NEXT(a_advance_result, advance, m_axis_tvalid)

endmodule
